[src/tape_machine_interpreter_unit_assert.svh]
// Assertion shorthands for the interpreter checks; clk and arst_n come from the using scope.
`ifndef TAPE_MACHINE_INTERPRETER_UNIT_ASSERT_SVH
`define TAPE_MACHINE_INTERPRETER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TMI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication.
`define TMI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

[src/tmi_pkg.sv]
package tmi_pkg;

	typedef logic [1:0] func_t;
	typedef logic [1:0] err_t;

	localparam func_t FUNC_LOAD  = 2'd0;
	localparam func_t FUNC_STEP  = 2'd1;
	localparam func_t FUNC_CLEAR = 2'd2;

	localparam err_t ERR_NONE      = 2'd0;
	localparam err_t ERR_UNMATCHED = 2'd1;
	localparam err_t ERR_FULL      = 2'd2;
	localparam err_t ERR_OVERFLOW  = 2'd3;

	localparam logic [7:0] OP_INC   = 8'h2B;
	localparam logic [7:0] OP_DEC   = 8'h2D;
	localparam logic [7:0] OP_RIGHT = 8'h3E;
	localparam logic [7:0] OP_LEFT  = 8'h3C;
	localparam logic [7:0] OP_OUT   = 8'h2E;
	localparam logic [7:0] OP_OPEN  = 8'h5B;
	localparam logic [7:0] OP_CLOSE = 8'h5D;

endpackage

[src/tape_machine_interpreter_unit.sv]
// Step, load and unused-func items pass S_IDLE, then S_STEP, S_LOAD or S_HOLD; one item in flight.
// A ']' load adds S_LINK: the match table has one write port and the pair needs two writes.
// Step and load items read program, match table, tape and stack memories at their accept edge and
// write back as S_STEP or S_LOAD ends. Clear zeroes the tape one cell per cycle, the last when the
// result register is free. Reset is asynchronous, active low; a tape sweep follows, in_ready low.
module tape_machine_interpreter_unit #(
	parameter int PROG_DEPTH  = 4096,
	parameter int TAPE_DEPTH  = 32768,
	parameter int STACK_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] code_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       halted,
	output logic [1:0] status
);

	localparam int PAW = $clog2(PROG_DEPTH);
	localparam int PCW = PAW + 1;
	localparam int TAW = $clog2(TAPE_DEPTH);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SCW = SAW + 1;

	localparam logic [PCW-1:0] PROG_END   = PCW'(PROG_DEPTH);
	localparam logic [TAW-1:0] TAPE_LAST  = TAW'(TAPE_DEPTH - 1);
	localparam logic [SCW-1:0] STACK_FULL = SCW'(STACK_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_LOAD,
		S_LINK,
		S_HOLD,
		S_CLEAR
	} state_t;

	// memories
	logic [7:0]     prog_mem  [PROG_DEPTH];
	logic [PCW-1:0] match_mem [PROG_DEPTH];
	logic [7:0]     tape_mem  [TAPE_DEPTH];
	logic [PAW-1:0] stk_mem   [STACK_DEPTH];

	logic [7:0]     prog_rd_q;
	logic [PCW-1:0] match_rd_q;
	logic [7:0]     tape_rd_q;
	logic [PAW-1:0] stk_rd_q;

	// control state
	state_t         state_q, state_d;
	logic [PCW-1:0] pc_q, pc_d;
	logic [PCW-1:0] len_q, len_d;
	logic [TAW-1:0] dp_q, dp_d;
	logic [SCW-1:0] cnt_q, cnt_d;
	tmi_pkg::err_t  err_q, err_d;
	logic [TAW-1:0] clr_q, clr_d;
	logic           pend_q, pend_d;

	logic           res_valid_q;
	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           halted_q;
	tmi_pkg::err_t  status_q;

	// payload registers
	logic [7:0]     code_q;
	logic [PAW-1:0] link_at_q;
	logic [PAW-1:0] link_to_q;

	// per-cycle controls
	logic           fin, adv;
	logic           emit;
	logic [7:0]     emit_byte;
	logic           prog_we, match_we, stk_we, tape_we;
	logic [PAW-1:0] match_wa;
	logic [PCW-1:0] match_wd;
	logic [TAW-1:0] tape_wa;
	logic [7:0]     tape_wd;
	logic [SCW-1:0] stk_ra;
	logic [PCW-1:0] jump_pc;

	assign stk_ra  = cnt_q - SCW'(1);
	assign jump_pc = (match_rd_q >= len_q) ? len_q : match_rd_q + PCW'(1);
	// a finishing cycle waits until the output register is free
	assign adv     = !fin || !res_valid_q || res_ready;

	always_comb begin
		state_d   = state_q;
		pc_d      = pc_q;
		len_d     = len_q;
		dp_d      = dp_q;
		cnt_d     = cnt_q;
		err_d     = err_q;
		clr_d     = clr_q;
		pend_d    = pend_q;
		fin       = 1'b0;
		emit      = 1'b0;
		emit_byte = 8'd0;
		prog_we   = 1'b0;
		match_we  = 1'b0;
		match_wa  = len_q[PAW-1:0];
		match_wd  = PROG_END;
		stk_we    = 1'b0;
		tape_we   = 1'b0;
		tape_wa   = dp_q;
		tape_wd   = 8'd0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (func)
						tmi_pkg::FUNC_LOAD:  state_d = S_LOAD;
						tmi_pkg::FUNC_STEP:  state_d = S_STEP;
						tmi_pkg::FUNC_CLEAR: begin
							pc_d    = '0;
							len_d   = '0;
							dp_d    = '0;
							cnt_d   = '0;
							err_d   = tmi_pkg::ERR_NONE;
							clr_d   = '0;
							pend_d  = 1'b1;
							state_d = S_CLEAR;
						end
						default:             state_d = S_HOLD;
					endcase
				end
			end
			S_STEP: begin
				fin     = 1'b1;
				state_d = S_IDLE;
				if (err_q == tmi_pkg::ERR_NONE && pc_q < len_q) begin
					pc_d = pc_q + PCW'(1);
					unique case (prog_rd_q)
						tmi_pkg::OP_INC: begin
							tape_we = 1'b1;
							tape_wd = tape_rd_q + 8'd1;
						end
						tmi_pkg::OP_DEC: begin
							tape_we = 1'b1;
							tape_wd = tape_rd_q - 8'd1;
						end
						tmi_pkg::OP_RIGHT: dp_d = (dp_q == TAPE_LAST) ? '0 : dp_q + TAW'(1);
						tmi_pkg::OP_LEFT:  dp_d = (dp_q == '0) ? TAPE_LAST : dp_q - TAW'(1);
						tmi_pkg::OP_OUT: begin
							emit      = 1'b1;
							emit_byte = tape_rd_q;
						end
						tmi_pkg::OP_OPEN: begin
							if (tape_rd_q == 8'd0) pc_d = jump_pc;
						end
						tmi_pkg::OP_CLOSE: begin
							if (tape_rd_q != 8'd0) pc_d = jump_pc;
						end
						default: ;
					endcase
				end
			end
			S_LOAD: begin
				fin     = 1'b1;
				state_d = S_IDLE;
				if (err_q == tmi_pkg::ERR_NONE) begin
					if (len_q >= PROG_END) begin
						err_d = tmi_pkg::ERR_FULL;
					end else if (code_q == tmi_pkg::OP_OPEN) begin
						if (cnt_q >= STACK_FULL) begin
							err_d = tmi_pkg::ERR_OVERFLOW;
						end else begin
							stk_we   = 1'b1;
							cnt_d    = cnt_q + SCW'(1);
							match_we = 1'b1;
							prog_we  = 1'b1;
							len_d    = len_q + PCW'(1);
						end
					end else if (code_q == tmi_pkg::OP_CLOSE) begin
						if (cnt_q == '0) begin
							err_d = tmi_pkg::ERR_UNMATCHED;
						end else begin
							// pop; the partner's entry is written in S_LINK
							cnt_d    = stk_ra;
							match_we = 1'b1;
							match_wd = PCW'(stk_rd_q);
							prog_we  = 1'b1;
							len_d    = len_q + PCW'(1);
							fin      = 1'b0;
							state_d  = S_LINK;
						end
					end else begin
						prog_we = 1'b1;
						len_d   = len_q + PCW'(1);
					end
				end
			end
			S_LINK: begin
				fin      = 1'b1;
				state_d  = S_IDLE;
				match_we = 1'b1;
				match_wa = link_to_q;
				match_wd = PCW'(link_at_q);
			end
			S_HOLD: begin
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			S_CLEAR: begin
				tape_we = 1'b1;
				tape_wa = clr_q;
				if (clr_q == TAPE_LAST) begin
					fin     = pend_q;
					pend_d  = 1'b0;
					state_d = S_IDLE;
				end else begin
					clr_d = clr_q + TAW'(1);
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			pc_q        <= '0;
			len_q       <= '0;
			dp_q        <= '0;
			cnt_q       <= '0;
			err_q       <= tmi_pkg::ERR_NONE;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= 8'd0;
			halted_q    <= 1'b0;
			status_q    <= tmi_pkg::ERR_NONE;
		end else begin
			if (adv) begin
				state_q <= state_d;
				pc_q    <= pc_d;
				len_q   <= len_d;
				dp_q    <= dp_d;
				cnt_q   <= cnt_d;
				err_q   <= err_d;
				clr_q   <= clr_d;
				pend_q  <= pend_d;
			end
			if (fin && adv) begin
				res_valid_q <= 1'b1;
				out_valid_q <= emit;
				out_byte_q  <= emit_byte;
				halted_q    <= (err_d != tmi_pkg::ERR_NONE) || (pc_d >= len_d);
				status_q    <= err_d;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) code_q <= code_byte;
		if (state_q == S_LOAD) begin
			link_at_q <= len_q[PAW-1:0];
			link_to_q <= stk_rd_q;
		end
	end

	// memory ports: reads are issued every cycle at the live pointers
	always_ff @(posedge clk) begin
		if (prog_we && adv) prog_mem[len_q[PAW-1:0]] <= code_q;
		prog_rd_q <= prog_mem[pc_q[PAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (match_we && adv) match_mem[match_wa] <= match_wd;
		match_rd_q <= match_mem[pc_q[PAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (tape_we && adv) tape_mem[tape_wa] <= tape_wd;
		tape_rd_q <= tape_mem[dp_q];
	end

	always_ff @(posedge clk) begin
		if (stk_we && adv) stk_mem[cnt_q[SAW-1:0]] <= len_q[PAW-1:0];
		stk_rd_q <= stk_mem[stk_ra[SAW-1:0]];
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign halted    = halted_q;
	assign status    = status_q;

endmodule

[src/tmi_checker.sv]
`include "tape_machine_interpreter_unit_assert.svh"

module tmi_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] func,
	input logic       res_valid,
	input logic       res_ready,
	input logic       out_valid,
	input logic [7:0] out_byte,
	input logic       halted,
	input logic [1:0] status
);

	// a result waiting on the consumer holds its payload
	`TMI_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(out_byte) && $stable(status))

	// non-output transactions carry a zero byte
	`TMI_ASSERT_NOW(a_byte_zero, res_valid && !out_valid, out_byte == 8'd0)

	// any error halts
	`TMI_ASSERT_NOW(a_err_halts, res_valid && status != tmi_pkg::ERR_NONE, halted)

	// output only from an error-free machine
	`TMI_ASSERT_NOW(a_out_ok, res_valid && out_valid, status == tmi_pkg::ERR_NONE)

	// a clear starts the tape sweep, which blocks input
	`TMI_ASSERT_NEXT(a_clear_busy, in_valid && in_ready && func == tmi_pkg::FUNC_CLEAR, !in_ready)

endmodule

bind tape_machine_interpreter_unit tmi_checker u_tmi_checker (.*);
